FILE: hw/rtl/lmfb_pkg.sv
// Shared types and constants for the LED matrix frame store.
// Used by lmfb_ctrl, lmfb_datapath and led_matrix_framebuffer; no dependencies.
`timescale 1ns / 1ps

package lmfb_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int MAX_HEIGHT  = 32;
    localparam int COLOUR_BITS = 32;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COORD_W     = 5;
    localparam int SIZE_W      = 6;
    localparam int OUT_COLOUR_W = 32;

    localparam logic [2:0] KIND_WRITE        = 3'd0;
    localparam logic [2:0] KIND_READ         = 3'd1;
    localparam logic [2:0] KIND_FILL         = 3'd2;
    localparam logic [2:0] KIND_CHECK_FILLED = 3'd3;
    localparam logic [2:0] KIND_CHECK_EMPTY  = 3'd4;

    localparam logic [1:0] REG_WIDTH      = 2'd0;
    localparam logic [1:0] REG_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_SERPENTINE = 2'd2;
    localparam logic [1:0] REG_COL_MAJOR  = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_fb_state;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic scan_en;
    } t_fb_cmd;

    typedef struct packed {
        logic clear_last;
        logic scan_last;
        logic has_pixels;
    } t_fb_stat;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              serpentine;
        logic              col_major;
    } t_fb_cfg;

endpackage

FILE: hw/rtl/lmfb_ctrl.sv
// Sequencing state machine: clearing sweep, pixel scan, drain and result strobe.
// Depends on lmfb_pkg.
`timescale 1ns / 1ps

module lmfb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lmfb_pkg::t_fb_stat i_stat,
    output lmfb_pkg::t_fb_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    lmfb_pkg::t_fb_state r_state;
    lmfb_pkg::t_fb_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmfb_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmfb_pkg::ST_CLEAR: begin
                if (i_stat.clear_last) n_state = lmfb_pkg::ST_IDLE;
            end
            lmfb_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = i_stat.has_pixels ? lmfb_pkg::ST_SCAN : lmfb_pkg::ST_DONE;
                end
            end
            lmfb_pkg::ST_SCAN: begin
                if (i_stat.scan_last) n_state = lmfb_pkg::ST_DRAIN;
            end
            lmfb_pkg::ST_DRAIN: n_state = lmfb_pkg::ST_DONE;
            lmfb_pkg::ST_DONE:  n_state = lmfb_pkg::ST_IDLE;
            default:            n_state = lmfb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.clear_en = (r_state == lmfb_pkg::ST_CLEAR);
        o_cmd.load     = (r_state == lmfb_pkg::ST_IDLE) && i_start;
        o_cmd.scan_en  = (r_state == lmfb_pkg::ST_SCAN);
        o_busy         = (r_state != lmfb_pkg::ST_IDLE);
        o_done         = (r_state == lmfb_pkg::ST_DONE);
    end

endmodule

FILE: hw/rtl/lmfb_datapath.sv
// Frame store memory, coordinate counters, strip-index mapping and result registers.
// Depends on lmfb_pkg; driven by lmfb_ctrl.
`timescale 1ns / 1ps

module lmfb_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lmfb_pkg::t_fb_cmd                     i_cmd,
    input  lmfb_pkg::t_fb_cfg                     i_cfg,
    input  logic [2:0]                            i_kind,
    input  logic [lmfb_pkg::COORD_W-1:0]          i_x_low,
    input  logic [lmfb_pkg::COORD_W-1:0]          i_y_low,
    input  logic [lmfb_pkg::COORD_W-1:0]          i_x_high,
    input  logic [lmfb_pkg::COORD_W-1:0]          i_y_high,
    input  logic [31:0]                           i_colour,
    output lmfb_pkg::t_fb_stat                    o_stat,
    output logic [lmfb_pkg::OUT_COLOUR_W-1:0]     o_read_colour,
    output logic                                  o_check_true,
    output logic                                  o_out_of_range
);

    localparam int CW = lmfb_pkg::COORD_W;
    localparam int SW = lmfb_pkg::SIZE_W;
    localparam int AW = lmfb_pkg::ADDR_W;
    localparam int BW = lmfb_pkg::COLOUR_BITS;
    localparam int PW = 2 * SW;

    logic [BW-1:0] r_mem [lmfb_pkg::STORE_DEPTH];

    logic [AW-1:0] r_clr_addr;
    logic [2:0]    r_kind;
    logic [BW-1:0] r_colour;
    logic [CW-1:0] r_x, r_y, r_y_start, r_x_end, r_y_end;
    logic [BW-1:0] r_rdata;
    logic          r_cmp_valid;
    logic [BW-1:0] r_rd;
    logic          r_chk;
    logic          r_oor;

    logic          single;
    logic          rect;
    logic          ordered;
    logic          inside_low;
    logic          high_out;
    logic [CW-1:0] x_end, y_end;
    logic          has_pixels;
    logic          oor;
    logic [AW-1:0] addr;
    logic          wr_kind;

    function automatic logic [AW-1:0] map_index(
        input logic [CW-1:0] x,
        input logic [CW-1:0] y,
        input lmfb_pkg::t_fb_cfg cfg
    );
        logic [PW-1:0] xe, ye, we, he, idx;
        xe = PW'(x);
        ye = PW'(y);
        we = PW'(cfg.width);
        he = PW'(cfg.height);
        if (!cfg.col_major) begin
            if (cfg.serpentine && y[0]) idx = ye * we + (we - 1'b1 - xe);
            else                        idx = ye * we + xe;
        end else begin
            if (cfg.serpentine && !x[0]) idx = he * (we - xe) - (ye + 1'b1);
            else                         idx = he * (we - 1'b1 - xe) + ye;
        end
        return idx[AW-1:0];
    endfunction

    always_comb begin
        single     = (i_kind == lmfb_pkg::KIND_WRITE) || (i_kind == lmfb_pkg::KIND_READ);
        rect       = (i_kind == lmfb_pkg::KIND_FILL) || (i_kind == lmfb_pkg::KIND_CHECK_FILLED)
                     || (i_kind == lmfb_pkg::KIND_CHECK_EMPTY);
        ordered    = (i_x_low <= i_x_high) && (i_y_low <= i_y_high);
        inside_low = (SW'(i_x_low) < i_cfg.width) && (SW'(i_y_low) < i_cfg.height);
        high_out   = (SW'(i_x_high) >= i_cfg.width) || (SW'(i_y_high) >= i_cfg.height);
        if (single) begin
            x_end      = i_x_low;
            y_end      = i_y_low;
            has_pixels = inside_low;
            oor        = !inside_low;
        end else begin
            x_end      = high_out && (SW'(i_x_high) >= i_cfg.width)
                         ? CW'(i_cfg.width - 1'b1) : i_x_high;
            y_end      = (SW'(i_y_high) >= i_cfg.height) ? CW'(i_cfg.height - 1'b1) : i_y_high;
            has_pixels = rect && ordered && inside_low;
            oor        = rect && ordered && high_out;
        end
    end

    assign addr    = map_index(r_x, r_y, i_cfg);
    assign wr_kind = (r_kind == lmfb_pkg::KIND_WRITE) || (r_kind == lmfb_pkg::KIND_FILL);

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.scan_en && wr_kind) begin
            r_mem[addr] <= r_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_en) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_en) r_clr_addr <= r_clr_addr + 1'b1;
            r_cmp_valid <= i_cmd.scan_en && !wr_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= i_kind;
            r_colour  <= i_colour[BW-1:0];
            r_x       <= i_x_low;
            r_y       <= i_y_low;
            r_y_start <= i_y_low;
            r_x_end   <= x_end;
            r_y_end   <= y_end;
            r_rd      <= '0;
            r_chk     <= (i_kind == lmfb_pkg::KIND_CHECK_FILLED)
                         || (i_kind == lmfb_pkg::KIND_CHECK_EMPTY);
            r_oor     <= oor;
        end else begin
            if (i_cmd.scan_en) begin
                if (r_y == r_y_end) begin
                    r_y <= r_y_start;
                    r_x <= r_x + 1'b1;
                end else begin
                    r_y <= r_y + 1'b1;
                end
            end
            if (r_cmp_valid) begin
                if (r_kind == lmfb_pkg::KIND_READ) r_rd <= r_rdata;
                if ((r_kind == lmfb_pkg::KIND_CHECK_FILLED) && (r_rdata != r_colour)) r_chk <= 1'b0;
                if ((r_kind == lmfb_pkg::KIND_CHECK_EMPTY) && (r_rdata != '0)) r_chk <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.clear_last = (r_clr_addr == {AW{1'b1}});
        o_stat.scan_last  = (r_x == r_x_end) && (r_y == r_y_end);
        o_stat.has_pixels = has_pixels;
    end

    assign o_read_colour  = lmfb_pkg::OUT_COLOUR_W'(r_rd);
    assign o_check_true   = r_chk;
    assign o_out_of_range = r_oor;

endmodule

FILE: hw/rtl/led_matrix_framebuffer.sv
// Top level of the LED matrix frame store: APB register file, controller and datapath.
// Depends on lmfb_pkg, lmfb_ctrl and lmfb_datapath.
`timescale 1ns / 1ps

// After reset the block sweeps the 1024-entry store to zero, one entry a cycle, and holds
// busy high until the sweep is done. A request is taken when start is high and busy low; it
// then visits its pixels one per cycle through the single-port store and finishes with a
// one-cycle o_done strobe carrying the result word, after the scan and drain states; a
// request that visits no pixel goes straight from idle to the strobe. The receiver cannot
// stall o_done: sample the result fields in the strobe cycle. The user must write size and
// wiring registers only while busy is low; the block itself does not enforce it.

module led_matrix_framebuffer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_kind,
    input  logic [lmfb_pkg::COORD_W-1:0]        i_x_low,
    input  logic [lmfb_pkg::COORD_W-1:0]        i_y_low,
    input  logic [lmfb_pkg::COORD_W-1:0]        i_x_high,
    input  logic [lmfb_pkg::COORD_W-1:0]        i_y_high,
    input  logic [31:0]                         i_colour,
    output logic                                o_done,
    output logic [lmfb_pkg::OUT_COLOUR_W-1:0]   o_read_colour,
    output logic                                o_check_true,
    output logic                                o_out_of_range
);

    localparam int SW = lmfb_pkg::SIZE_W;

    logic [SW-1:0] r_width;
    logic [SW-1:0] r_height;
    logic          r_serpentine;
    logic          r_col_major;

    logic                wr_en;
    lmfb_pkg::t_fb_cfg   cfg;
    lmfb_pkg::t_fb_cmd   cmd;
    lmfb_pkg::t_fb_stat  stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= SW'(32);
            r_height     <= SW'(32);
            r_serpentine <= 1'b0;
            r_col_major  <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                lmfb_pkg::REG_WIDTH:      r_width      <= pwdata[SW-1:0];
                lmfb_pkg::REG_HEIGHT:     r_height     <= pwdata[SW-1:0];
                lmfb_pkg::REG_SERPENTINE: r_serpentine <= pwdata[0];
                lmfb_pkg::REG_COL_MAJOR:  r_col_major  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            lmfb_pkg::REG_WIDTH:      prdata = 32'(r_width);
            lmfb_pkg::REG_HEIGHT:     prdata = 32'(r_height);
            lmfb_pkg::REG_SERPENTINE: prdata = 32'(r_serpentine);
            lmfb_pkg::REG_COL_MAJOR:  prdata = 32'(r_col_major);
            default:                  prdata = '0;
        endcase
    end

    // saturate sizes to 1..MAX
    always_comb begin
        if (r_width == '0)                              cfg.width = SW'(1);
        else if (r_width > SW'(lmfb_pkg::MAX_WIDTH))    cfg.width = SW'(lmfb_pkg::MAX_WIDTH);
        else                                            cfg.width = r_width;
        if (r_height == '0)                             cfg.height = SW'(1);
        else if (r_height > SW'(lmfb_pkg::MAX_HEIGHT))  cfg.height = SW'(lmfb_pkg::MAX_HEIGHT);
        else                                            cfg.height = r_height;
        cfg.serpentine = r_serpentine;
        cfg.col_major  = r_col_major;
    end

    lmfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    lmfb_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_kind         (i_kind),
        .i_x_low        (i_x_low),
        .i_y_low        (i_y_low),
        .i_x_high       (i_x_high),
        .i_y_high       (i_y_high),
        .i_colour       (i_colour),
        .o_stat         (stat),
        .o_read_colour  (o_read_colour),
        .o_check_true   (o_check_true),
        .o_out_of_range (o_out_of_range)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> busy)
        else $error("store clearing sweep not running after reset");

    a_unknown_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind > lmfb_pkg::KIND_CHECK_EMPTY)) |=>
            (o_done && !o_check_true && !o_out_of_range && (o_read_colour == '0)))
        else $error("unknown request kind did not give an empty result");

    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_check_true) |-> (o_read_colour == '0))
        else $error("check result carried read data");

endmodule

FILE: tb/led_matrix_framebuffer_checker.sv
// Checker for the LED matrix frame store: keeps its own copy of the frame and of the
// size and wiring registers, predicts each result word and compares it with o_done.
// Depends on lmfb_pkg; instantiated beside the block by led_matrix_framebuffer_tb.
`timescale 1ns / 1ps

module led_matrix_framebuffer_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    input  logic                                pready,
    input  logic                                start,
    input  logic                                busy,
    input  logic [2:0]                          i_kind,
    input  logic [lmfb_pkg::COORD_W-1:0]        i_x_low,
    input  logic [lmfb_pkg::COORD_W-1:0]        i_y_low,
    input  logic [lmfb_pkg::COORD_W-1:0]        i_x_high,
    input  logic [lmfb_pkg::COORD_W-1:0]        i_y_high,
    input  logic [31:0]                         i_colour,
    input  logic                                o_done,
    input  logic [lmfb_pkg::OUT_COLOUR_W-1:0]   o_read_colour,
    input  logic                                o_check_true,
    input  logic                                o_out_of_range,
    output int                                  o_fail_count,
    output int                                  o_words_owed,
    output int                                  o_words_checked
);

    typedef struct packed {
        logic [lmfb_pkg::OUT_COLOUR_W-1:0] read_colour;
        logic                              check_true;
        logic                              out_of_range;
    } t_pixel_word;

    logic [lmfb_pkg::COLOUR_BITS-1:0] frame_image [lmfb_pkg::STORE_DEPTH];
    logic [lmfb_pkg::SIZE_W-1:0]      cols_reg;
    logic [lmfb_pkg::SIZE_W-1:0]      rows_reg;
    logic                             serp_reg;
    logic                             colmaj_reg;
    t_pixel_word                      owed_words [$];
    int                               fail_cnt;
    int                               checked_cnt;

    function automatic int unsigned strip_index(input int unsigned x, input int unsigned y,
                                                input int unsigned w, input int unsigned h);
        int unsigned idx;
        if (!colmaj_reg) begin
            if (serp_reg && (y % 2) == 1)
                idx = y * w + (w - 1 - x);
            else
                idx = y * w + x;
        end else begin
            if (serp_reg && (x % 2) == 0)
                idx = h * (w - x) - (y + 1);
            else
                idx = h * (w - 1 - x) + y;
        end
        return idx % lmfb_pkg::STORE_DEPTH;
    endfunction

    task automatic predict_request(input logic [2:0] kind, input int unsigned xl,
                                   input int unsigned yl, input int unsigned xh,
                                   input int unsigned yh, input logic [31:0] colour);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned idx;
        t_pixel_word want;
        logic [lmfb_pkg::COLOUR_BITS-1:0] c;
        c = colour[lmfb_pkg::COLOUR_BITS-1:0];
        w = (cols_reg == 0) ? 1
            : ((cols_reg > lmfb_pkg::MAX_WIDTH) ? lmfb_pkg::MAX_WIDTH : cols_reg);
        h = (rows_reg == 0) ? 1
            : ((rows_reg > lmfb_pkg::MAX_HEIGHT) ? lmfb_pkg::MAX_HEIGHT : rows_reg);
        want = '0;
        unique case (kind)
            lmfb_pkg::KIND_WRITE, lmfb_pkg::KIND_READ: begin
                if (xl >= w || yl >= h) begin
                    want.out_of_range = 1'b1;
                end else begin
                    idx = strip_index(xl, yl, w, h);
                    if (kind == lmfb_pkg::KIND_WRITE)
                        frame_image[idx] = c;
                    else
                        want.read_colour = frame_image[idx];
                end
            end
            lmfb_pkg::KIND_FILL, lmfb_pkg::KIND_CHECK_FILLED, lmfb_pkg::KIND_CHECK_EMPTY: begin
                want.check_true = (kind != lmfb_pkg::KIND_FILL);
                if (xl <= xh && yl <= yh) begin
                    if (xh >= w || yh >= h)
                        want.out_of_range = 1'b1;
                    for (x = xl; x <= xh && x < w; x++) begin
                        for (y = yl; y <= yh && y < h; y++) begin
                            idx = strip_index(x, y, w, h);
                            if (kind == lmfb_pkg::KIND_FILL)
                                frame_image[idx] = c;
                            else if (kind == lmfb_pkg::KIND_CHECK_FILLED) begin
                                if (frame_image[idx] != c)
                                    want.check_true = 1'b0;
                            end else if (frame_image[idx] != '0) begin
                                want.check_true = 1'b0;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        owed_words.push_back(want);
    endtask

    always @(posedge i_clk) begin
        t_pixel_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < lmfb_pkg::STORE_DEPTH; i++)
                frame_image[i] = '0;
            cols_reg   = 6'd32;
            rows_reg   = 6'd32;
            serp_reg   = 1'b0;
            colmaj_reg = 1'b0;
            owed_words.delete();
        end else begin
            if (o_done) begin
                if (owed_words.size() == 0) begin
                    $error("result word with no request outstanding");
                    fail_cnt++;
                end else begin
                    want = owed_words.pop_front();
                    checked_cnt++;
                    if (o_read_colour !== want.read_colour) begin
                        $error("read_colour: expected %h, got %h",
                               want.read_colour, o_read_colour);
                        fail_cnt++;
                    end
                    if (o_check_true !== want.check_true) begin
                        $error("check_true: expected %b, got %b",
                               want.check_true, o_check_true);
                        fail_cnt++;
                    end
                    if (o_out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %b, got %b",
                               want.out_of_range, o_out_of_range);
                        fail_cnt++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                unique case (paddr[3:2])
                    lmfb_pkg::REG_WIDTH:      cols_reg   = pwdata[lmfb_pkg::SIZE_W-1:0];
                    lmfb_pkg::REG_HEIGHT:     rows_reg   = pwdata[lmfb_pkg::SIZE_W-1:0];
                    lmfb_pkg::REG_SERPENTINE: serp_reg   = pwdata[0];
                    lmfb_pkg::REG_COL_MAJOR:  colmaj_reg = pwdata[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_request(i_kind, i_x_low, i_y_low, i_x_high, i_y_high, i_colour);
        end
        o_fail_count    <= fail_cnt;
        o_words_owed    <= owed_words.size();
        o_words_checked <= checked_cnt;
    end

endmodule

FILE: tb/led_matrix_framebuffer_tb.sv
// Testbench top for the LED matrix frame store: clock, reset, APB register writes and
// request stimulus; verdict from the failure count of led_matrix_framebuffer_checker.
// Depends on lmfb_pkg, led_matrix_framebuffer and led_matrix_framebuffer_checker.
`timescale 1ns / 1ps

module led_matrix_framebuffer_tb;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int PHASE_REQUESTS = 56;
    localparam int PHASE_COUNT    = 10;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [3:0]                           paddr;
    logic [31:0]                          pwdata;
    logic [31:0]                          prdata;
    logic                                 pready;
    logic                                 start;
    logic                                 busy;
    logic [2:0]                           req_kind;
    logic [lmfb_pkg::COORD_W-1:0]         req_x_low;
    logic [lmfb_pkg::COORD_W-1:0]         req_y_low;
    logic [lmfb_pkg::COORD_W-1:0]         req_x_high;
    logic [lmfb_pkg::COORD_W-1:0]         req_y_high;
    logic [31:0]                          req_colour;
    logic                                 o_done;
    logic [lmfb_pkg::OUT_COLOUR_W-1:0]    o_read_colour;
    logic                                 o_check_true;
    logic                                 o_out_of_range;
    int                                   fail_count;
    int                                   words_owed;
    int                                   words_checked;
    int                                   cycle_count;
    int                                   requests_sent;
    int                                   settings_used;
    int                                   idle_pct;
    int                                   cur_w;
    int                                   cur_h;

    led_matrix_framebuffer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_kind         (req_kind),
        .i_x_low        (req_x_low),
        .i_y_low        (req_y_low),
        .i_x_high       (req_x_high),
        .i_y_high       (req_y_high),
        .i_colour       (req_colour),
        .o_done         (o_done),
        .o_read_colour  (o_read_colour),
        .o_check_true   (o_check_true),
        .o_out_of_range (o_out_of_range)
    );

    led_matrix_framebuffer_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .i_kind          (req_kind),
        .i_x_low         (req_x_low),
        .i_y_low         (req_y_low),
        .i_x_high        (req_x_high),
        .i_y_high        (req_y_high),
        .i_colour        (req_colour),
        .o_done          (o_done),
        .o_read_colour   (o_read_colour),
        .o_check_true    (o_check_true),
        .o_out_of_range  (o_out_of_range),
        .o_fail_count    (fail_count),
        .o_words_owed    (words_owed),
        .o_words_checked (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk); while (busy || words_owed != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [lmfb_pkg::SIZE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {$urandom_range(0, 1) ? 26'($urandom) : 26'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(input int w, input int h, input logic serp, input logic cmaj);
        start <= 1'b0;
        wait_idle();
        write_reg(lmfb_pkg::REG_WIDTH, lmfb_pkg::SIZE_W'(w));
        write_reg(lmfb_pkg::REG_HEIGHT, lmfb_pkg::SIZE_W'(h));
        write_reg(lmfb_pkg::REG_SERPENTINE, {5'd0, serp});
        write_reg(lmfb_pkg::REG_COL_MAJOR, {5'd0, cmaj});
        cur_w = (w < 1) ? 1 : ((w > lmfb_pkg::MAX_WIDTH) ? lmfb_pkg::MAX_WIDTH : w);
        cur_h = (h < 1) ? 1 : ((h > lmfb_pkg::MAX_HEIGHT) ? lmfb_pkg::MAX_HEIGHT : h);
        settings_used++;
    endtask

    task automatic issue_request(input logic [2:0] k, input int xl, input int yl,
                                 input int xh, input int yh, input logic [31:0] c);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        req_kind   <= k;
        req_x_low  <= lmfb_pkg::COORD_W'(xl);
        req_y_low  <= lmfb_pkg::COORD_W'(yl);
        req_x_high <= lmfb_pkg::COORD_W'(xh);
        req_y_high <= lmfb_pkg::COORD_W'(yh);
        req_colour <= c;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        requests_sent++;
        idle_pct = (requests_sent < 200) ? 21 : ((requests_sent < 400) ? 52 : 0);
    endtask

    function automatic logic [31:0] pick_colour();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'h0;
        if (r < 20)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Mostly small rectangles starting inside the frame; a few whole-frame, a few arbitrary.
    task automatic pick_span(input int lim, output int lo, output int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            lo = 0;
            hi = 31;
        end else if (r < 14) begin
            lo = $urandom_range(0, 31);
            hi = $urandom_range(0, 31);
        end else begin
            lo = $urandom_range(0, lim - 1);
            hi = lo + $urandom_range(0, 3);
            if (hi > 31)
                hi = 31;
        end
    endtask

    // Fill, confirm, read one pixel, sometimes disturb it and re-check, check empty, and sometimes clear again.
    task automatic run_scene();
        int xl, xh, yl, yh, px, py;
        logic [31:0] c;
        pick_span(cur_w, xl, xh);
        pick_span(cur_h, yl, yh);
        c  = pick_colour();
        px = (xl <= xh) ? xl + $urandom_range(0, xh - xl) : xl;
        py = (yl <= yh) ? yl + $urandom_range(0, yh - yl) : yl;
        issue_request(lmfb_pkg::KIND_FILL, xl, yl, xh, yh, c);
        issue_request(lmfb_pkg::KIND_CHECK_FILLED, xl, yl, xh, yh, c);
        issue_request(lmfb_pkg::KIND_READ, px, py, $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom);
        if ($urandom_range(0, 1)) begin
            issue_request(lmfb_pkg::KIND_WRITE, px, py, $urandom_range(0, 31),
                          $urandom_range(0, 31), pick_colour());
            issue_request(lmfb_pkg::KIND_CHECK_FILLED, xl, yl, xh, yh, c);
        end
        issue_request(lmfb_pkg::KIND_CHECK_EMPTY, xl, yl, xh, yh, $urandom);
        if ($urandom_range(0, 2) == 0) begin
            issue_request(lmfb_pkg::KIND_FILL, xl, yl, xh, yh, 32'h0);
            issue_request(lmfb_pkg::KIND_CHECK_EMPTY, xl, yl, xh, yh, $urandom);
        end
    endtask

    task automatic run_single();
        int xl, xh, yl, yh;
        logic [2:0] k;
        k = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        if (k == lmfb_pkg::KIND_WRITE || k == lmfb_pkg::KIND_READ) begin
            xl = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, cur_w - 1);
            yl = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, cur_h - 1);
            xh = $urandom_range(0, 31);
            yh = $urandom_range(0, 31);
        end else begin
            pick_span(cur_w, xl, xh);
            pick_span(cur_h, yl, yh);
        end
        issue_request(k, xl, yl, xh, yh, pick_colour());
    endtask

    initial begin
        int phase_end;
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        req_kind   = lmfb_pkg::KIND_WRITE;
        req_x_low  = '0;
        req_y_low  = '0;
        req_x_high = '0;
        req_y_high = '0;
        req_colour = '0;
        requests_sent = 0;
        settings_used = 1;
        idle_pct   = 21;
        cur_w      = lmfb_pkg::MAX_WIDTH;
        cur_h      = lmfb_pkg::MAX_HEIGHT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait_idle();

        // reset wiring, full 32 by 32 frame
        issue_request(lmfb_pkg::KIND_READ, 0, 0, 31, 31, 32'hFFFF_FFFF);
        issue_request(lmfb_pkg::KIND_CHECK_EMPTY, 0, 0, 31, 31, 32'h0);
        issue_request(lmfb_pkg::KIND_WRITE, 31, 31, 0, 0, 32'hFFFF_FFFF);
        issue_request(lmfb_pkg::KIND_READ, 31, 31, 0, 0, 32'h0);
        issue_request(lmfb_pkg::KIND_WRITE, 0, 0, 0, 0, 32'hA5A5_5A5A);
        issue_request(lmfb_pkg::KIND_READ, 0, 0, 31, 31, 32'h0);
        issue_request(lmfb_pkg::KIND_FILL, 2, 3, 5, 6, 32'h1234_5678);
        issue_request(lmfb_pkg::KIND_CHECK_FILLED, 2, 3, 5, 6, 32'h1234_5678);
        issue_request(lmfb_pkg::KIND_CHECK_FILLED, 2, 3, 5, 6, 32'h1234_5679);
        issue_request(lmfb_pkg::KIND_CHECK_EMPTY, 2, 3, 5, 6, 32'h0);
        issue_request(lmfb_pkg::KIND_FILL, 5, 0, 2, 3, 32'hDEAD_BEEF);
        issue_request(lmfb_pkg::KIND_CHECK_FILLED, 5, 0, 2, 3, 32'hDEAD_BEEF);
        issue_request(lmfb_pkg::KIND_CHECK_EMPTY, 0, 6, 3, 2, 32'h0);
        for (int k = 5; k <= 7; k++)
            issue_request(3'(k), $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
        issue_request(lmfb_pkg::KIND_CHECK_EMPTY, 0, 0, 31, 31, 32'h0);

        // small frame, serpentine columns: out-of-size pixels and rectangles
        apply_setting(8, 4, 1'b1, 1'b1);
        issue_request(lmfb_pkg::KIND_WRITE, 10, 1, 0, 0, 32'h5555_AAAA);
        issue_request(lmfb_pkg::KIND_READ, 1, 10, 0, 0, 32'h0);
        issue_request(lmfb_pkg::KIND_FILL, 6, 2, 12, 6, 32'h0F0F_F0F0);
        issue_request(lmfb_pkg::KIND_CHECK_FILLED, 6, 2, 12, 6, 32'h0F0F_F0F0);
        issue_request(lmfb_pkg::KIND_CHECK_EMPTY, 10, 5, 20, 9, 32'h0);
        issue_request(lmfb_pkg::KIND_WRITE, 7, 3, 31, 31, 32'h8000_0001);
        issue_request(lmfb_pkg::KIND_READ, 7, 3, 31, 31, 32'h0);
        issue_request(lmfb_pkg::KIND_FILL, 0, 0, 31, 31, 32'h0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: apply_setting(32, 32, 1'b0, 1'b0);
                1: apply_setting(32, 32, 1'b1, 1'b0);
                2: apply_setting(32, 32, 1'b0, 1'b1);
                3: apply_setting(32, 32, 1'b1, 1'b1);
                4: apply_setting(1, 1, 1'b1, 1'b1);
                5: apply_setting(0, 63, 1'b0, 1'b1);
                6: apply_setting(63, 0, 1'b1, 1'b0);
                default: apply_setting($urandom_range(1, 32), $urandom_range(1, 32),
                                       1'($urandom), 1'($urandom));
            endcase
            phase_end = requests_sent + PHASE_REQUESTS;
            while (requests_sent < phase_end) begin
                if ($urandom_range(0, 99) < 55)
                    run_scene();
                else
                    run_single();
            end
        end

        start <= 1'b0;
        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d result words from %0d requests over %0d size and wiring settings",
                 words_checked, requests_sent, settings_used);
        $display("Pixel writes and reads, fills and both checks, with sender gaps and without");
        if (fail_count == 0 && words_owed == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/lmfb_pkg.sv
hw/rtl/lmfb_ctrl.sv
hw/rtl/lmfb_datapath.sv
hw/rtl/led_matrix_framebuffer.sv
tb/led_matrix_framebuffer_checker.sv
tb/led_matrix_framebuffer_tb.sv
